### design/drpf_pkg.sv
// ----------------------------------------------------------------------------
// drpf_pkg
// Shared types and constants for the reverse-complement palindrome finder.
// ----------------------------------------------------------------------------
package drpf_pkg;

  // default sizing
  localparam int unsigned WINDOW_BASES_DEF = 12;
  localparam int unsigned MAX_SEQ_LEN_DEF  = 65536;

  // field widths
  localparam int unsigned BASE_W  = 2;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 4;

  // longest site ever tested and number of even lengths up to it
  localparam int unsigned LONGEST_SITE = 12;
  localparam int unsigned NUM_LENGTHS  = LONGEST_SITE / 2;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // complement of a base: A<->T, C<->G
  localparam logic [BASE_W-1:0] COMP_MASK = 2'b11;

  // register reset values
  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 4'd4;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 4'd12;

  // register indexes on the config port
  typedef enum logic {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_e;

  // length bounds seen by the front
  typedef struct packed {
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
  } cfg_t;

  // one classified base: end position and one hit bit per even length
  typedef struct packed {
    logic [START_W-1:0]     end_pos;
    logic [NUM_LENGTHS-1:0] hits;
  } job_t;

endpackage

### design/drpf_front.sv
// ----------------------------------------------------------------------------
// drpf_front
// Takes bases, keeps the window and position, and tests every even length
// in parallel; a base with hits becomes one request for the back part.
// ----------------------------------------------------------------------------
module drpf_front #(
  parameter int unsigned WINDOW_BASES = drpf_pkg::WINDOW_BASES_DEF,
  parameter int unsigned MAX_SEQ_LEN  = drpf_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [drpf_pkg::BASE_W-1:0] base_i,
  input  logic                        first_base_i,
  input  drpf_pkg::cfg_t              cfg_i,
  input  logic                        full_i,
  output logic                        push_o,
  output drpf_pkg::job_t              job_o
);

  localparam int unsigned VW = $clog2(WINDOW_BASES + 1);
  localparam int unsigned PW = $clog2(MAX_SEQ_LEN + 1);

  logic [drpf_pkg::BASE_W-1:0]      win_q   [WINDOW_BASES];
  logic [drpf_pkg::BASE_W-1:0]      win_d   [WINDOW_BASES];
  logic [VW-1:0]                    valid_q, valid_d;
  logic [PW-1:0]                    pos_q, pos_d;
  logic [PW-1:0]                    cur;
  logic [PW+drpf_pkg::START_W-1:0]  cur_ext;
  logic                             report;
  logic                             accept;
  logic [drpf_pkg::NUM_LENGTHS-1:0] hit;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  // window after this base, cleared first on a new sequence
  always_comb begin
    win_d[0] = base_i;
    for (int k = 1; k < WINDOW_BASES; k++) begin
      win_d[k] = first_base_i ? '0 : win_q[k-1];
    end
  end

  // valid count and position, both saturating
  always_comb begin
    if (first_base_i) begin
      valid_d = VW'(1);
    end else if (valid_q < VW'(WINDOW_BASES)) begin
      valid_d = valid_q + VW'(1);
    end else begin
      valid_d = valid_q;
    end
    cur    = first_base_i ? '0 : pos_q;
    report = (cur < PW'(MAX_SEQ_LEN));
    pos_d  = report ? cur + PW'(1) : cur;
  end

  // one comparator bank per even length
  for (genvar j = 0; j < drpf_pkg::NUM_LENGTHS; j++) begin : g_len
    localparam int unsigned L = 2 * j + 2;
    if (L <= WINDOW_BASES) begin : g_on
      logic pal;
      always_comb begin
        pal = 1'b1;
        for (int k = 0; k < L / 2; k++) begin
          if (win_d[L-1-k] != (win_d[k] ^ drpf_pkg::COMP_MASK)) pal = 1'b0;
        end
        hit[j] = pal && (VW'(L) <= valid_d) &&
                 (drpf_pkg::LEN_W'(L) >= cfg_i.min_len) &&
                 (drpf_pkg::LEN_W'(L) <= cfg_i.max_len);
      end
    end else begin : g_off
      assign hit[j] = 1'b0;
    end
  end

  // request to the queue
  assign cur_ext       = {{drpf_pkg::START_W{1'b0}}, cur};
  assign job_o.end_pos = cur_ext[drpf_pkg::START_W-1:0];
  assign job_o.hits    = hit;
  assign push_o        = accept & report & (|hit);

  // window payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  // count and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  // count never passes the window size
  a_valid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q <= VW'(WINDOW_BASES))
    else $error("window count beyond window size");

endmodule

### design/drpf_queue.sv
// ----------------------------------------------------------------------------
// drpf_queue
// Short first-in first-out queue of requests between front and back.
// ----------------------------------------------------------------------------
module drpf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  drpf_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output drpf_pkg::job_t job_o
);

  localparam int unsigned AW = $clog2(drpf_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(drpf_pkg::QUEUE_DEPTH + 1);

  drpf_pkg::job_t mem_q [drpf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CW'(drpf_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i)  rd_q <= rd_q + AW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // no write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  // no read from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

### design/drpf_back.sv
// ----------------------------------------------------------------------------
// drpf_back
// Walks the hit bits of each request from shortest length up and emits one
// site per cycle through an output register.
// ----------------------------------------------------------------------------
module drpf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  drpf_pkg::job_t               q_job_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [drpf_pkg::START_W-1:0] site_start_o,
  output logic [drpf_pkg::LEN_W-1:0]   site_length_o,
  output logic                         last_of_run_o
);

  localparam int unsigned NL = drpf_pkg::NUM_LENGTHS;

  logic                         busy_q, busy_d;
  logic [NL-1:0]                mask_q, mask_d;
  logic [drpf_pkg::START_W-1:0] end_q, end_d;
  logic                         out_valid_q, out_valid_d;
  logic [drpf_pkg::START_W-1:0] start_q, start_d;
  logic [drpf_pkg::LEN_W-1:0]   len_q, len_d;
  logic                         last_q, last_d;
  logic                         advance;
  logic [NL-1:0]                low_bit;
  logic [NL-1:0]                rest;
  logic [drpf_pkg::LEN_W-1:0]   low_len;

  assign advance = !out_valid_q || !out_stall_i;

  // shortest remaining length
  always_comb begin
    low_bit = '0;
    low_len = '0;
    for (int j = NL - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        low_bit = '0;
        low_bit[j] = 1'b1;
        low_len = drpf_pkg::LEN_W'(2 * j + 2);
      end
    end
    rest = mask_q & ~low_bit;
  end

  // emit one site, take the next request when this one runs out
  always_comb begin
    busy_d      = busy_q;
    mask_d      = mask_q;
    end_d       = end_q;
    out_valid_d = out_valid_q;
    start_d     = start_q;
    len_d       = len_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    if (advance) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        start_d = end_q + drpf_pkg::START_W'(1) - drpf_pkg::START_W'(low_len);
        len_d   = low_len;
        last_d  = (rest == '0);
        mask_d  = rest;
      end
      if (!busy_q || rest == '0) begin
        busy_d  = q_valid_i;
        q_pop_o = q_valid_i;
        mask_d  = q_job_i.hits;
        end_d   = q_job_i.end_pos;
      end
    end
  end

  // request in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    end_q   <= end_d;
    start_q <= start_d;
    len_q   <= len_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign site_start_o  = start_q;
  assign site_length_o = len_q;
  assign last_of_run_o = last_q;

  // a request in progress always has a length left
  a_busy_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (mask_q != '0))
    else $error("busy with no hits left");

  // every site has a nonzero even length
  a_even_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (len_q != '0 && !len_q[0]))
    else $error("bad site length");

endmodule

### design/dna_reverse_palindrome_finder_unit.sv
// Takes one 2-bit base per cycle and reports each reverse-complement
// palindrome of even length between min_length and max_length that ends at
// that base, as a zero-based start and a length, shortest first, with
// last_of_run on the final site of a base. Bases are taken at one per cycle
// as long as the four-entry request queue has room; all lengths are tested
// at once by parallel comparators. Sites leave at one per cycle unless the
// output stalls; the queue absorbs bursts from bases with several sites.
// Each site passes the queue, the back's request state and output register.
// ----------------------------------------------------------------------------
// dna_reverse_palindrome_finder_unit
// Top level: config registers on an APB-style port, front, queue and back.
// ----------------------------------------------------------------------------
module dna_reverse_palindrome_finder_unit #(
  parameter int unsigned WINDOW_BASES = drpf_pkg::WINDOW_BASES_DEF,
  parameter int unsigned MAX_SEQ_LEN  = drpf_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // bases in
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [drpf_pkg::BASE_W-1:0]  base_i,
  input  logic                         first_base_i,
  // sites out
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [drpf_pkg::START_W-1:0] site_start_o,
  output logic [drpf_pkg::LEN_W-1:0]   site_length_o,
  output logic                         last_of_run_o
);

  drpf_pkg::cfg_t     cfg_q;
  drpf_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;
  logic               push, full, pop, q_valid;
  drpf_pkg::job_t     job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = drpf_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len <= drpf_pkg::MIN_LENGTH_RST;
      cfg_q.max_len <= drpf_pkg::MAX_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        drpf_pkg::REG_MIN_LENGTH: cfg_q.min_len <= pwdata[drpf_pkg::LEN_W-1:0];
        drpf_pkg::REG_MAX_LENGTH: cfg_q.max_len <= pwdata[drpf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      drpf_pkg::REG_MIN_LENGTH: prdata = {28'b0, cfg_q.min_len};
      drpf_pkg::REG_MAX_LENGTH: prdata = {28'b0, cfg_q.max_len};
      default:                  prdata = '0;
    endcase
  end

  // classify bases
  drpf_front #(
    .WINDOW_BASES(WINDOW_BASES),
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_i      (base_i),
    .first_base_i(first_base_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // request queue
  drpf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (job_out)
  );

  // emit sites
  drpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (job_out),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .site_start_o (site_start_o),
    .site_length_o(site_length_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

### verif/drpf_site_checker.sv
// ----------------------------------------------------------------------------
// drpf_site_checker
// Watches the config port and both channels of the palindrome finder, keeps
// its own copy of the base window and the length bounds, works out the sites
// each accepted base should report and compares them with what comes out.
// ----------------------------------------------------------------------------
module drpf_site_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config port
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [2:0]                   paddr_i,
  input  logic [31:0]                  pwdata_i,
  input  logic                         pready_i,
  // bases in
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [drpf_pkg::BASE_W-1:0]  base_i,
  input  logic                         first_base_i,
  // sites out
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [drpf_pkg::START_W-1:0] site_start_i,
  input  logic [drpf_pkg::LEN_W-1:0]   site_length_i,
  input  logic                         last_of_run_i,
  // status for the test top
  output int unsigned                  errors_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN     = drpf_pkg::WINDOW_BASES_DEF;
  localparam int unsigned MAX_POS = drpf_pkg::MAX_SEQ_LEN_DEF;

  typedef struct packed {
    logic [drpf_pkg::START_W-1:0] start_pos;
    logic [drpf_pkg::LEN_W-1:0]   bases;
    logic                         closes_run;
  } site_t;

  // predictor state
  logic [drpf_pkg::BASE_W-1:0] window_q [WIN];
  int unsigned                 valid_cnt;
  int unsigned                 seq_pos;
  logic [drpf_pkg::LEN_W-1:0]  min_len;
  logic [drpf_pkg::LEN_W-1:0]  max_len;
  site_t                       sites_due [$];
  int unsigned                 mismatches = 0;

  assign errors_o = mismatches;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: site mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // shift a base in and queue every site that ends at it
  task automatic find_sites(input logic [drpf_pkg::BASE_W-1:0] b, input logic fb);
    logic [drpf_pkg::NUM_LENGTHS-1:0] hits;
    int unsigned                      cur;
    int unsigned                      len;
    site_t                            s;
    if (fb) begin
      for (int k = 0; k < WIN; k++) window_q[k] = '0;
      valid_cnt = 0;
      seq_pos   = 0;
    end
    for (int k = WIN - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    if (valid_cnt < WIN) valid_cnt++;
    cur = seq_pos;
    if (seq_pos < MAX_POS) seq_pos++;
    // saturated positions report nothing
    if (cur >= MAX_POS) return;
    hits = '0;
    for (int i = 0; i < drpf_pkg::NUM_LENGTHS; i++) begin
      len = 2 * (i + 1);
      if (len < min_len || len > max_len || len > WIN || len > valid_cnt) continue;
      hits[i] = 1'b1;
      for (int k = 0; k < len / 2; k++)
        if (window_q[len-1-k] != (window_q[k] ^ drpf_pkg::COMP_MASK)) hits[i] = 1'b0;
    end
    for (int i = 0; i < drpf_pkg::NUM_LENGTHS; i++) begin
      if (!hits[i]) continue;
      len          = 2 * (i + 1);
      s.start_pos  = drpf_pkg::START_W'(cur + 1 - len);
      s.bases      = drpf_pkg::LEN_W'(len);
      s.closes_run = ((hits >> (i + 1)) == '0);
      sites_due.insert(sites_due.size(), s);
    end
  endtask

  // compare one accepted site with the oldest one due
  task automatic check_site();
    site_t want;
    if (sites_due.size() == 0) begin
      report_mismatch("unexpected site start", site_start_i, '0);
      return;
    end
    want = sites_due.pop_front();
    if (site_start_i !== want.start_pos)
      report_mismatch("site_start", site_start_i, want.start_pos);
    if (site_length_i !== want.bases)
      report_mismatch("site_length", site_length_i, want.bases);
    if (last_of_run_i !== want.closes_run)
      report_mismatch("last_of_run", last_of_run_i, want.closes_run);
  endtask

  // monitor all three ports
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN; k++) window_q[k] = '0;
      valid_cnt = 0;
      seq_pos   = 0;
      min_len   = drpf_pkg::MIN_LENGTH_RST;
      max_len   = drpf_pkg::MAX_LENGTH_RST;
      sites_due.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (drpf_pkg::reg_idx_e'(paddr_i[2]))
          drpf_pkg::REG_MIN_LENGTH: min_len = pwdata_i[drpf_pkg::LEN_W-1:0];
          drpf_pkg::REG_MAX_LENGTH: max_len = pwdata_i[drpf_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_site();
      if (in_valid_i && !in_stall_i) find_sites(base_i, first_base_i);
      pending_o <= sites_due.size();
    end
  end

endmodule

### verif/dna_reverse_palindrome_finder_unit_test.sv
// ----------------------------------------------------------------------------
// dna_reverse_palindrome_finder_unit_test
// Streams base requests into the palindrome finder through a range of length
// bounds, with bursty input and a stalling output; the checker beside the
// block predicts every site and counts mismatches.
// ----------------------------------------------------------------------------
module dna_reverse_palindrome_finder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT      = 200_000;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned RANDOM_PER_PHASE = 36;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_HALF,
    FLOW_HEAVY,
    FLOW_PERIODIC
  } flow_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  base       = '0;
  logic        first_base = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [15:0] site_start;
  logic [3:0]  site_length;
  logic        last_of_run;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles      = 0;
  int unsigned bases_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned flow_left   = 0;
  flow_e       flow_mode   = FLOW_FREE;

  dna_reverse_palindrome_finder_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .base_i        (base),
    .first_base_i  (first_base),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .site_start_o  (site_start),
    .site_length_o (site_length),
    .last_of_run_o (last_of_run)
  );

  drpf_site_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .base_i        (base),
    .first_base_i  (first_base),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .site_start_i  (site_start),
    .site_length_i (site_length),
    .last_of_run_i (last_of_run),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output stall pattern, switching to a random mode after each random run
  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow_mode = flow_e'($urandom_range(0, 3));
      flow_left = $urandom_range(8, 64);
    end
    flow_left--;
    case (flow_mode)
      FLOW_FREE:  out_stall <= 1'b0;
      FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= (flow_left % 3 == 0);
    endcase
  end

  // one base request, sent in bursts with random gaps
  task automatic send_base(input logic [1:0] b, input logic fb);
    int unsigned gap;
    logic        taken;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    base       <= b;
    first_base <= fb;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    bases_sent++;
  endtask

  // wait until every site is out and the block has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // config write: setup then access, junk in the upper data bits
  task automatic write_reg(input drpf_pkg::reg_idx_e idx, input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bounds(input logic [3:0] lo, input logic [3:0] hi);
    wait_idle();
    write_reg(drpf_pkg::REG_MIN_LENGTH, lo);
    write_reg(drpf_pkg::REG_MAX_LENGTH, hi);
  endtask

  // planted palindromes half the time, else random runs or lone bases
  task automatic send_segment();
    logic [1:0]  half [6];
    int unsigned h;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      h = $urandom_range(1, 6);
      for (int k = 0; k < h; k++) half[k] = 2'($urandom());
      for (int k = 0; k < h; k++)
        send_base(half[k], (k == 0) && ($urandom_range(0, 4) == 0));
      for (int k = h; k > 0; k--) send_base(half[k-1] ^ drpf_pkg::COMP_MASK, 1'b0);
    end else if (pick < 8) begin
      repeat ($urandom_range(1, 8)) send_base(2'($urandom()), 1'b0);
    end else begin
      send_base(2'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic run_phase(input logic [3:0] lo, input logic [3:0] hi);
    int unsigned target;
    set_bounds(lo, hi);
    target = bases_sent + RANDOM_PER_PHASE;
    while (bases_sent < target) send_segment();
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bounds, alternating A/T: every even window of 4 or more is a hit
    for (int k = 0; k < 14; k++) send_base((k % 2) ? BASE_T : BASE_A, k == 0);

    // widest bounds, alternating G/C with a restart mid-way
    set_bounds(4'd2, 4'd12);
    for (int k = 0; k < 14; k++)
      send_base((k % 2) ? BASE_C : BASE_G, (k == 0) || (k == 8));

    // random phases, extremes and odd or inverted bounds among them
    run_phase(4'd2, 4'd2);
    run_phase(4'd12, 4'd12);
    run_phase(4'd0, 4'd15);
    run_phase(4'd1, 4'd3);
    run_phase(4'd5, 4'd9);
    run_phase(4'd8, 4'd4);
    run_phase(4'd15, 4'd0);
    run_phase(4'd13, 4'd14);
    run_phase(4'd6, 4'd6);
    run_phase(4'd3, 4'd11);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));

    // out-of-range bounds on a restarted A/T run: every length reports
    set_bounds(4'd0, 4'd15);
    for (int k = 0; k < 20; k++) send_base((k % 2) ? BASE_T : BASE_A, k == 0);

    wait_idle();
    @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/drpf_pkg.sv
design/drpf_front.sv
design/drpf_queue.sv
design/drpf_back.sv
design/dna_reverse_palindrome_finder_unit.sv
verif/drpf_site_checker.sv
verif/dna_reverse_palindrome_finder_unit_test.sv
